FILE: rtl/tscf_pkg.sv
// Package for the text stream cat filter: configuration and job types,
// character codes, register indexes. No dependencies.
package tscf_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH       = 4;
    localparam int ADDR_W            = 5;
    localparam int DATA_W            = 32;

    localparam logic [2:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_NONBLANK = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_HIGH   = 8'h80;
    localparam logic [7:0] CH_META_C = 8'hA0;
    localparam logic [7:0] CH_FF     = 8'hFF;
    localparam logic [7:0] CTRL_OFS  = 8'h40;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    // one classified request: optional prefix, optional pad, 1..4 body bytes
    typedef struct packed {
        logic            num_en;
        logic            pad;
        logic [1:0]      body_last;
        logic [3:0][7:0] body;
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

FILE: rtl/tscf_front.sv
// Front end of the text stream cat filter: accepts bytes, tracks line state
// and the BCD line number, classifies each byte into a job. Uses tscf_pkg.
module tscf_front
    import tscf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_byte,
    input  logic                       i_file_start,
    input  logic                       i_full,
    output logic                       o_push,
    output t_job                       o_job,
    output logic [4*NUMBER_DIGITS-1:0] o_bcd
);

    localparam int BW = 4 * NUMBER_DIGITS;

    logic          r_at_start, n_at_start;
    logic [BW-1:0] r_bcd, n_bcd;
    logic [1:0]    r_blank, n_blank;

    logic          accept, at_ls, empty_line, squeezed;
    logic [BW-1:0] bcd_cur, bcd_inc;
    logic [1:0]    blank_cur, blank_new;
    logic          all_nines, carry;
    t_job          job;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign at_ls      = i_file_start || r_at_start;
    assign bcd_cur    = i_file_start ? BW'(1) : r_bcd;
    assign blank_cur  = i_file_start ? 2'd0 : r_blank;
    assign empty_line = at_ls && (i_byte == CH_NL);
    assign blank_new  = empty_line ? ((blank_cur == 2'd2) ? 2'd2 : blank_cur + 2'd1) : 2'd0;
    assign squeezed   = empty_line && i_cfg.squeeze_blank && (blank_new == 2'd2);

    always_comb begin
        all_nines = 1'b1;
        carry     = 1'b1;
        bcd_inc   = bcd_cur;
        for (int d = 0; d < NUMBER_DIGITS; d++) begin
            if (bcd_cur[4*d +: 4] != 4'd9) all_nines = 1'b0;
            if (carry) begin
                if (bcd_cur[4*d +: 4] >= 4'd9) begin
                    bcd_inc[4*d +: 4] = 4'd0;
                end else begin
                    bcd_inc[4*d +: 4] = bcd_cur[4*d +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb begin
        job           = '0;
        job.num_en    = at_ls && !squeezed && ((i_cfg.number_mode == MODE_ALL) ||
                        ((i_cfg.number_mode == MODE_NONBLANK) && !empty_line));
        job.body[0]   = i_byte;
        job.body_last = 2'd0;
        if (i_cfg.show_nonprinting && (i_byte >= CH_HIGH)) begin
            job.body[0] = CH_M;
            job.body[1] = CH_DASH;
            if (i_byte == CH_FF) begin
                job.body[2]   = CH_CARET;
                job.body[3]   = CH_QMARK;
                job.body_last = 2'd3;
            end else if (i_byte < CH_META_C) begin
                job.body[2]   = CH_CARET;
                job.body[3]   = i_byte - CTRL_OFS;
                job.body_last = 2'd3;
            end else begin
                job.body[2]   = i_byte - CH_HIGH;
                job.body_last = 2'd2;
            end
        end else if (i_cfg.show_nonprinting && (i_byte < CH_SPACE) &&
                     (i_byte != CH_TAB) && (i_byte != CH_NL)) begin
            job.body[0]   = CH_CARET;
            job.body[1]   = i_byte + CTRL_OFS;
            job.body_last = 2'd1;
        end else if (i_cfg.show_nonprinting && (i_byte == CH_DEL)) begin
            job.body[0]   = CH_CARET;
            job.body[1]   = CH_QMARK;
            job.body_last = 2'd1;
        end else if (i_cfg.show_ends && (i_byte == CH_NL)) begin
            job.pad       = empty_line && (i_cfg.number_mode == MODE_NONBLANK);
            job.body[0]   = CH_DOLLAR;
            job.body[1]   = CH_NL;
            job.body_last = 2'd1;
        end else if (i_cfg.show_tabs && (i_byte == CH_TAB)) begin
            job.body[0]   = CH_CARET;
            job.body[1]   = CH_I;
            job.body_last = 2'd1;
        end
    end

    assign n_at_start = (i_byte == CH_NL);
    assign n_blank    = at_ls ? blank_new : blank_cur;
    assign n_bcd      = (job.num_en && !all_nines) ? bcd_inc : bcd_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_bcd      <= BW'(1);
            r_blank    <= 2'd0;
        end else if (accept) begin
            r_at_start <= n_at_start;
            r_bcd      <= n_bcd;
            r_blank    <= n_blank;
        end
    end

    assign o_push = accept && !squeezed;
    assign o_job  = job;
    assign o_bcd  = bcd_cur;

    a_squeeze_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && squeezed) |-> !o_push)
        else $error("squeezed empty line was queued");

endmodule

FILE: rtl/tscf_fifo.sv
// Short request queue between front and back end. Uses tscf_pkg for its
// depth.
module tscf_fifo
    import tscf_pkg::*;
#(
    parameter int WIDTH = JOB_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

FILE: rtl/tscf_back.sv
// Back end of the text stream cat filter, uses tscf_pkg: walks the job at the
// queue head and, unless stalled, drives one byte per cycle via a register stage.
module tscf_back
    import tscf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  t_job                       i_job,
    input  logic [4*NUMBER_DIGITS-1:0] i_bcd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_data,
    output logic                       o_last
);

    localparam int KW = ($clog2(NUMBER_DIGITS + 1) > 2) ? $clog2(NUMBER_DIGITS + 1) : 2;
    localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    typedef enum logic [1:0] {PH_NUM, PH_PAD, PH_BODY} t_phase;

    t_phase        r_phase, phase, nxt_phase;
    logic [KW-1:0] r_k, k, nxt_k, dsel_full;
    logic [DW-1:0] dsel;
    logic          r_busy, r_lead, lead, lead_now;
    logic          r_valid, r_last;
    logic [7:0]    r_data;
    logic [7:0]    byte_now;
    logic [3:0]    dig;
    logic          last_now, adv, emit;

    assign adv  = !r_valid || i_ready;
    assign emit = adv && !i_empty;

    always_comb begin
        if (r_busy) phase = r_phase;
        else if (i_job.num_en) phase = PH_NUM;
        else if (i_job.pad) phase = PH_PAD;
        else phase = PH_BODY;
    end
    assign k    = r_busy ? r_k : '0;
    assign lead = r_busy ? r_lead : 1'b1;

    assign dsel_full = KW'(NUMBER_DIGITS - 1) - k;
    assign dsel      = dsel_full[DW-1:0];
    assign dig       = i_bcd[4*dsel +: 4];
    assign lead_now  = lead && (dig == 4'd0) && (dsel != '0);

    always_comb begin
        byte_now  = CH_TAB;
        last_now  = 1'b0;
        nxt_phase = phase;
        nxt_k     = k + KW'(1);
        unique case (phase)
            PH_NUM: begin
                if (k != KW'(NUMBER_DIGITS)) begin
                    byte_now = lead_now ? CH_SPACE :
                               CH_ZERO + {4'd0, (dig > 4'd9) ? 4'd9 : dig};
                end else begin
                    nxt_phase = i_job.pad ? PH_PAD : PH_BODY;
                    nxt_k     = '0;
                end
            end
            PH_PAD: begin
                if (k != KW'(NUMBER_DIGITS)) begin
                    byte_now = CH_SPACE;
                end else begin
                    nxt_phase = PH_BODY;
                    nxt_k     = '0;
                end
            end
            PH_BODY: begin
                byte_now = i_job.body[k[1:0]];
                last_now = (k[1:0] == i_job.body_last);
            end
            default: begin
                byte_now = CH_TAB;
            end
        endcase
    end

    assign o_pop = emit && last_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_phase <= PH_BODY;
            r_k     <= '0;
            r_lead  <= 1'b1;
            r_data  <= '0;
            r_last  <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
            r_busy  <= !last_now;
            r_phase <= nxt_phase;
            r_k     <= nxt_k;
            r_lead  <= lead_now;
            r_data  <= byte_now;
            r_last  <= last_now;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_valid && o_last))
        else $error("request retired without a final byte");

    a_busy_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_empty)
        else $error("request in progress but queue empty");

endmodule

FILE: rtl/text_stream_cat_filter.sv
// Top level of the text stream cat filter: APB register file, front end,
// request queue and back end. Uses tscf_pkg, tscf_front, tscf_fifo, tscf_back.
//
// One text byte enters per request (tuser carries the file-start flag) and
// leaves as 1 to 4 body bytes, preceded by a NUMBER_DIGITS-wide line number
// and a tab, or by a blank pad and a tab, at the start of a line. The front
// end takes a byte every cycle while its 4-entry queue has room; the back end
// writes one output byte per cycle while m_tready is high; a byte yields 1 to
// NUMBER_DIGITS+5 output bytes (none for a squeezed empty line); sustained rate
// is set by the output port. The user writes registers only while the block is
// idle, which the block does not enforce; no clearing pass follows reset.
module text_stream_cat_filter
    import tscf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tuser,   // [0] file_start
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int BW = 4 * NUMBER_DIGITS;
    localparam int QW = JOB_W + BW;

    t_cfg          r_cfg;
    logic [2:0]    reg_idx;
    logic          push, pop, full, empty;
    t_job          f_job, b_job;
    logic [BW-1:0] f_bcd, b_bcd;
    logic [QW-1:0] q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_NUMBER_MODE:      r_cfg.number_mode      <= pwdata[1:0];
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= pwdata[0];
                REG_SHOW_ENDS:        r_cfg.show_ends        <= pwdata[0];
                REG_SHOW_TABS:        r_cfg.show_tabs        <= pwdata[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_NUMBER_MODE:      prdata = {30'd0, r_cfg.number_mode};
            REG_SQUEEZE_BLANK:    prdata = {31'd0, r_cfg.squeeze_blank};
            REG_SHOW_ENDS:        prdata = {31'd0, r_cfg.show_ends};
            REG_SHOW_TABS:        prdata = {31'd0, r_cfg.show_tabs};
            REG_SHOW_NONPRINTING: prdata = {31'd0, r_cfg.show_nonprinting};
            default:              prdata = '0;
        endcase
    end

    tscf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_byte       (s_tdata),
        .i_file_start (s_tuser),
        .i_full       (full),
        .o_push       (push),
        .o_job        (f_job),
        .o_bcd        (f_bcd)
    );

    tscf_fifo #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_bcd, f_job}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign b_job = q_out[JOB_W-1:0];
    assign b_bcd = q_out[QW-1:JOB_W];

    tscf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (b_job),
        .i_bcd   (b_bcd),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata),
        .o_last  (m_tlast)
    );

endmodule
